// File: hdl/bei_pkg.sv
// Shared types and constants of the breakpoint envelope interpolator.
`timescale 1ns / 1ps

package bei_pkg;

    localparam int MAX_POINTS = 16;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int COUNT_W    = 5;
    localparam int DATA_W     = 32;
    localparam int DIV_STEPS  = DATA_W + 1;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    // Item opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    // Result region codes
    localparam logic [1:0] REGION_BEFORE = 2'd0;
    localparam logic [1:0] REGION_AFTER  = 2'd1;
    localparam logic [1:0] REGION_INTERP = 2'd2;
    localparam logic [1:0] REGION_NONE   = 2'd3;

    // One classified item on its way from the front end to the engine
    typedef struct packed {
        logic                     is_eval;
        logic [IDX_W-1:0]         slot;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] phase;
    } t_cmd;

    // Engine sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_LAST,
        S_CHK_LAST,
        S_SCAN,
        S_MUL_LO,
        S_MUL_HI,
        S_DIV,
        S_FIN,
        S_DONE
    } t_state;

endpackage

// File: hdl/bei_if.sv
// Valid/ready channel interfaces for input items and result items.
`timescale 1ns / 1ps

interface bei_in_if;
    logic                             valid;
    logic                             ready;
    logic                             op;
    logic [bei_pkg::IDX_W-1:0]        point_index;
    logic signed [bei_pkg::DATA_W-1:0] point_x;
    logic signed [bei_pkg::DATA_W-1:0] point_y;
    logic signed [bei_pkg::DATA_W-1:0] phase;

    modport source (output valid, op, point_index, point_x, point_y, phase, input ready);
    modport sink   (input valid, op, point_index, point_x, point_y, phase, output ready);
endinterface

interface bei_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [bei_pkg::DATA_W-1:0] level;
    logic [1:0]                       region;
    logic [bei_pkg::IDX_W-1:0]        segment;

    modport source (output valid, level, region, segment, input ready);
    modport sink   (input valid, level, region, segment, output ready);
endinterface

// File: hdl/bei_front.sv
// Front end: accepts input beats, classifies them and queues them for the engine.
`timescale 1ns / 1ps

module bei_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    bei_in_if.sink         i_in,
    output bei_pkg::t_cmd  o_cmd,
    output logic           o_cmd_valid,
    input  logic           i_cmd_ready
);

    bei_pkg::t_cmd r_q [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;

    bei_pkg::t_cmd w_cmd;
    logic          w_push;
    logic          w_pop;

    // Classify the incoming beat
    always_comb begin
        w_cmd.is_eval = (i_in.op == bei_pkg::OP_EVAL);
        w_cmd.slot    = i_in.point_index;
        w_cmd.x       = i_in.point_x;
        w_cmd.y       = i_in.point_y;
        w_cmd.phase   = i_in.phase;
    end

    assign i_in.ready  = (r_cnt != 2'd2);
    assign w_push      = i_in.valid && i_in.ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign w_pop       = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rp];

    // Store queued items
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    // Advance queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: hdl/bei_engine.sv
// Back end: breakpoint tables, segment scan, multiply, divide and result register.
`timescale 1ns / 1ps

module bei_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bei_pkg::t_cmd                 i_cmd,
    input  logic                          i_cmd_valid,
    output logic                          o_cmd_ready,
    input  logic [bei_pkg::COUNT_W-1:0]   i_point_count,
    bei_out_if.source                     o_out
);

    localparam int DW = bei_pkg::DATA_W;
    localparam int IW = bei_pkg::IDX_W;

    // Breakpoint tables
    logic signed [DW-1:0] mem_x [bei_pkg::MAX_POINTS];
    logic signed [DW-1:0] mem_y [bei_pkg::MAX_POINTS];
    logic signed [DW-1:0] r_xq;
    logic signed [DW-1:0] r_yq;

    bei_pkg::t_state r_state;
    bei_pkg::t_state n_state;

    logic signed [DW-1:0] r_phase;
    logic [IW-1:0]        r_last;
    logic [IW-1:0]        r_idx;
    logic signed [DW-1:0] r_y_first;
    logic signed [DW-1:0] r_x_first;
    logic signed [DW-1:0] r_xp;
    logic signed [DW-1:0] r_yp;
    logic signed [DW-1:0] r_y0;
    logic [DW:0]          r_mag;
    logic                 r_neg;
    logic [DW-1:0]        r_u;
    logic [DW-1:0]        r_d;
    logic [2*DW:0]        r_prod;
    logic [DW-1:0]        r_rem;
    logic [DW:0]          r_dvd;
    logic [DW:0]          r_quo;
    logic [bei_pkg::STEP_W-1:0] r_step;
    logic signed [DW-1:0] r_level;
    logic [1:0]           r_region;
    logic [IW-1:0]        r_seg;

    logic                 r_ovalid;
    logic signed [DW-1:0] r_olevel;
    logic [1:0]           r_oregion;
    logic [IW-1:0]        r_oseg;

    logic [IW-1:0]        w_rd_addr;
    logic                 w_we;
    logic                 w_start;
    logic                 w_out_load;
    logic [IW-1:0]        w_last;
    logic                 w_match;
    logic [DW:0]          w_dx;
    logic [DW:0]          w_du;
    logic [DW:0]          w_dy;
    logic [15:0]          w_mul_b;
    logic [DW+16:0]       w_mul;
    logic [2*DW:0]        w_prod_hi;
    logic [DW:0]          w_trial;
    logic                 w_qbit;
    logic [DW:0]          w_sub;
    logic [DW+1:0]        w_sum;

    // Clamp the point count into a last index
    always_comb begin
        if (i_point_count < bei_pkg::COUNT_W'(2)) begin
            w_last = IW'(1);
        end else if (i_point_count > bei_pkg::COUNT_W'(bei_pkg::MAX_POINTS)) begin
            w_last = IW'(bei_pkg::MAX_POINTS - 1);
        end else begin
            w_last = IW'(i_point_count - bei_pkg::COUNT_W'(1));
        end
    end

    // Segment test and differences of the current pair
    assign w_match = (r_phase >= r_xp) && (r_phase <= r_xq);
    assign w_dx    = {r_xq[DW-1], r_xq} - {r_xp[DW-1], r_xp};
    assign w_du    = {r_phase[DW-1], r_phase} - {r_xp[DW-1], r_xp};
    assign w_dy    = {r_yq[DW-1], r_yq} - {r_yp[DW-1], r_yp};

    // Shared 33x16 multiplier
    assign w_mul_b   = (r_state == bei_pkg::S_MUL_LO) ? r_u[15:0] : r_u[DW-1:16];
    assign w_mul     = (DW+17)'(r_mag) * (DW+17)'(w_mul_b);
    assign w_prod_hi = r_prod + ((2*DW+1)'(w_mul) << 16);

    // One restoring division step
    assign w_trial = {r_rem, r_dvd[DW]};
    assign w_qbit  = (w_trial >= {1'b0, r_d});
    assign w_sub   = w_trial - {1'b0, r_d};

    // Apply the signed quotient to the segment start
    assign w_sum = r_neg ? ({{2{r_y0[DW-1]}}, r_y0} - {1'b0, r_quo})
                         : ({{2{r_y0[DW-1]}}, r_y0} + {1'b0, r_quo});

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bei_pkg::S_IDLE: begin
                if (i_cmd_valid && i_cmd.is_eval) begin
                    n_state = bei_pkg::S_RD_LAST;
                end
            end
            bei_pkg::S_RD_LAST: begin
                n_state = bei_pkg::S_CHK_LAST;
            end
            bei_pkg::S_CHK_LAST: begin
                if (r_phase <= r_x_first || r_phase >= r_xq) begin
                    n_state = bei_pkg::S_DONE;
                end else begin
                    n_state = bei_pkg::S_SCAN;
                end
            end
            bei_pkg::S_SCAN: begin
                if (w_match) begin
                    n_state = (w_dx == '0) ? bei_pkg::S_DONE : bei_pkg::S_MUL_LO;
                end else if (r_idx == r_last) begin
                    n_state = bei_pkg::S_DONE;
                end
            end
            bei_pkg::S_MUL_LO: begin
                n_state = bei_pkg::S_MUL_HI;
            end
            bei_pkg::S_MUL_HI: begin
                n_state = bei_pkg::S_DIV;
            end
            bei_pkg::S_DIV: begin
                if (r_step == bei_pkg::STEP_W'(bei_pkg::DIV_STEPS - 1)) begin
                    n_state = bei_pkg::S_FIN;
                end
            end
            bei_pkg::S_FIN: begin
                n_state = bei_pkg::S_DONE;
            end
            bei_pkg::S_DONE: begin
                if (w_out_load) begin
                    n_state = bei_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bei_pkg::S_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_cmd_ready = 1'b0;
        w_rd_addr   = '0;
        w_out_load  = 1'b0;
        case (r_state)
            bei_pkg::S_IDLE: begin
                o_cmd_ready = 1'b1;
                w_rd_addr   = '0;
            end
            bei_pkg::S_RD_LAST: begin
                w_rd_addr = r_last;
            end
            bei_pkg::S_CHK_LAST: begin
                w_rd_addr = IW'(1);
            end
            bei_pkg::S_SCAN: begin
                w_rd_addr = r_idx + IW'(1);
            end
            bei_pkg::S_DONE: begin
                w_out_load = !r_ovalid || o_out.ready;
            end
            default: begin
                w_rd_addr = '0;
            end
        endcase
    end

    assign w_we    = (r_state == bei_pkg::S_IDLE) && i_cmd_valid && !i_cmd.is_eval;
    assign w_start = (r_state == bei_pkg::S_IDLE) && i_cmd_valid && i_cmd.is_eval;

    // Write a breakpoint, read the addressed one
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_x[i_cmd.slot] <= i_cmd.x;
            mem_y[i_cmd.slot] <= i_cmd.y;
        end
        r_xq <= mem_x[w_rd_addr];
        r_yq <= mem_y[w_rd_addr];
    end

    // Hold the sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bei_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_phase <= i_cmd.phase;
            r_last  <= w_last;
        end
        case (r_state)
            bei_pkg::S_RD_LAST: begin
                r_x_first <= r_xq;
                r_y_first <= r_yq;
                r_xp      <= r_xq;
                r_yp      <= r_yq;
            end
            bei_pkg::S_CHK_LAST: begin
                r_idx <= IW'(1);
                r_seg <= '0;
                if (r_phase <= r_x_first) begin
                    r_level  <= r_y_first;
                    r_region <= bei_pkg::REGION_BEFORE;
                end else begin
                    r_level  <= r_yq;
                    r_region <= bei_pkg::REGION_AFTER;
                end
            end
            bei_pkg::S_SCAN: begin
                if (w_match) begin
                    r_seg    <= r_idx - IW'(1);
                    r_region <= bei_pkg::REGION_INTERP;
                    r_level  <= r_yp;
                    r_y0     <= r_yp;
                    r_neg    <= w_dy[DW];
                    r_mag    <= w_dy[DW] ? (DW+1)'(-w_dy) : w_dy;
                    r_u      <= w_du[DW-1:0];
                    r_d      <= w_dx[DW-1:0];
                end else begin
                    r_xp     <= r_xq;
                    r_yp     <= r_yq;
                    r_idx    <= r_idx + IW'(1);
                    r_region <= bei_pkg::REGION_NONE;
                    r_level  <= r_y_first;
                    r_seg    <= '0;
                end
            end
            bei_pkg::S_MUL_LO: begin
                r_prod <= (2*DW+1)'(w_mul);
            end
            bei_pkg::S_MUL_HI: begin
                r_rem  <= w_prod_hi[2*DW:DW+1];
                r_dvd  <= w_prod_hi[DW:0];
                r_quo  <= '0;
                r_step <= '0;
            end
            bei_pkg::S_DIV: begin
                r_rem  <= w_qbit ? w_sub[DW-1:0] : w_trial[DW-1:0];
                r_dvd  <= {r_dvd[DW-1:0], 1'b0};
                r_quo  <= {r_quo[DW-1:0], w_qbit};
                r_step <= r_step + bei_pkg::STEP_W'(1);
            end
            bei_pkg::S_FIN: begin
                // Saturate to signed 32 bits
                if (w_sum[DW+1:DW-1] == 3'b000 || w_sum[DW+1:DW-1] == 3'b111) begin
                    r_level <= w_sum[DW-1:0];
                end else if (w_sum[DW+1]) begin
                    r_level <= {1'b1, {(DW-1){1'b0}}};
                end else begin
                    r_level <= {1'b0, {(DW-1){1'b1}}};
                end
            end
            default: begin
                r_step <= r_step;
            end
        endcase
    end

    // Result register: load when empty or being drained
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_out_load) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_olevel  <= r_level;
            r_oregion <= r_region;
            r_oseg    <= r_seg;
        end
    end

    assign o_out.valid   = r_ovalid;
    assign o_out.level   = r_olevel;
    assign o_out.region  = r_oregion;
    assign o_out.segment = r_oseg;

endmodule

// File: hdl/breakpoint_envelope_interpolator_core.sv
// Top level of the breakpoint envelope interpolator.
`timescale 1ns / 1ps
// Usage:
//   i_in carries items: op 0 loads point_x/point_y into table slot point_index,
//   op 1 evaluates phase and yields one result beat on o_out (level, region,
//   segment). Load beats yield no result.
//   i_cfg_we/i_cfg_wdata set the number of breakpoints in use; write it only
//   while no evaluation is in flight. Reset sets it to 2.
// Sequence:
//   A two-entry queue takes input beats while the engine works. A load is
//   written to the tables from the idle state. An evaluation at or outside
//   the end points skips the scan; otherwise one segment is scanned per
//   cycle (at most 15), and a segment of nonzero width is interpolated with
//   two multiply steps on a shared 33x16 multiplier, 33 steps of the
//   restoring divider and one saturation step.
// Reset and stall:
//   Synchronous active-low reset empties the queue and the result register;
//   table contents stay undefined until loaded. A result waits in the output
//   register while o_out.ready is low; the engine holds its next result until
//   that register frees, and the queue fills and then drops i_in.ready.

module breakpoint_envelope_interpolator_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    bei_in_if.sink                      i_in,
    bei_out_if.source                   o_out,
    input  logic                        i_cfg_we,
    input  logic [bei_pkg::COUNT_W-1:0] i_cfg_wdata
);

    logic [bei_pkg::COUNT_W-1:0] r_point_count;
    bei_pkg::t_cmd               w_cmd;
    logic                        w_cmd_valid;
    logic                        w_cmd_ready;

    // Point count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= bei_pkg::COUNT_W'(2);
        end else if (i_cfg_we) begin
            r_point_count <= i_cfg_wdata;
        end
    end

    bei_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd       (w_cmd),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready)
    );

    bei_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_cmd_valid   (w_cmd_valid),
        .o_cmd_ready   (w_cmd_ready),
        .i_point_count (r_point_count),
        .o_out         (o_out)
    );

endmodule

// File: sim/envelope_checker.sv
// Result checker for the breakpoint envelope interpolator: predicts levels and compares beats.
`timescale 1ns / 1ps

module envelope_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    bei_in_if                           i_in_ch,
    bei_out_if                          i_out_ch,
    input  logic                        i_cfg_we,
    input  logic [bei_pkg::COUNT_W-1:0] i_cfg_wdata,
    output int                          o_fail_count,
    output int                          o_pending
);
    import bei_pkg::*;

    typedef struct packed {
        logic signed [DATA_W-1:0] level;
        logic [1:0]               region;
        logic [IDX_W-1:0]         segment;
    } t_level_beat;

    logic signed [DATA_W-1:0] x_table [MAX_POINTS];
    logic signed [DATA_W-1:0] y_table [MAX_POINTS];
    logic [COUNT_W-1:0]       points_in_use = COUNT_W'(2);
    t_level_beat              expected_levels [$];
    int                       mismatch_count = 0;

    // Work out the level of one phase from the mirrored breakpoint table
    function automatic t_level_beat predict_level(logic signed [DATA_W-1:0] ph);
        t_level_beat     res;
        int              n;
        longint          lvl, x0, x1, y0, y1, dy;
        longint unsigned mag, u, d, q;
        bit              found;
        n = int'(points_in_use);
        if (n < 2) n = 2;
        if (n > MAX_POINTS) n = MAX_POINTS;
        lvl         = y_table[0];
        res.region  = REGION_NONE;
        res.segment = '0;
        found       = 1'b0;
        if (ph <= x_table[0]) begin
            res.region = REGION_BEFORE;
        end else if (ph >= x_table[n-1]) begin
            lvl        = y_table[n-1];
            res.region = REGION_AFTER;
        end else begin
            // Take the first segment in table order that holds the phase
            for (int i = 0; i + 1 < n; i++) begin
                x0 = x_table[i];
                x1 = x_table[i+1];
                if (!found && ph >= x0 && ph <= x1) begin
                    found = 1'b1;
                    y0    = y_table[i];
                    y1    = y_table[i+1];
                    lvl   = y0;
                    // A zero-width segment keeps its first level
                    if (x1 > x0) begin
                        dy  = y1 - y0;
                        u   = ph - x0;
                        d   = x1 - x0;
                        mag = (dy < 0) ? -dy : dy;
                        q   = (mag * u) / d;
                        lvl = (dy < 0) ? y0 - longint'(q) : y0 + longint'(q);
                    end
                    res.region  = REGION_INTERP;
                    res.segment = IDX_W'(i);
                end
            end
        end
        // Saturate to signed 32 bits
        if (lvl > longint'(32'sh7FFF_FFFF)) lvl = longint'(32'sh7FFF_FFFF);
        if (lvl < longint'(32'sh8000_0000)) lvl = longint'(32'sh8000_0000);
        res.level = lvl[DATA_W-1:0];
        return res;
    endfunction

    // Count a failure, report only the first few
    function automatic void note_failure(string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    // Watch both channels and the register port at every edge
    always @(posedge i_clk) begin
        t_level_beat got;
        t_level_beat want;
        if (!i_rst_n) begin
            points_in_use = COUNT_W'(2);
            expected_levels.delete();
        end else begin
            if (i_cfg_we) points_in_use = i_cfg_wdata;

            // Compare a result beat with the oldest prediction
            if (i_out_ch.valid && i_out_ch.ready) begin
                got.level   = i_out_ch.level;
                got.region  = i_out_ch.region;
                got.segment = i_out_ch.segment;
                if (expected_levels.size() == 0) begin
                    note_failure($sformatf("unexpected result beat: level %h region %0d seg %0d",
                        got.level, got.region, got.segment));
                end else begin
                    want = expected_levels.pop_front();
                    if (got.level !== want.level || got.region !== want.region ||
                        got.segment !== want.segment) begin
                        note_failure($sformatf(
                            "mismatch: expected level %h region %0d seg %0d, got %h %0d %0d",
                            want.level, want.region, want.segment,
                            got.level, got.region, got.segment));
                    end
                end
            end

            // Mirror loads, predict evaluations
            if (i_in_ch.valid && i_in_ch.ready) begin
                if (i_in_ch.op == OP_EVAL) begin
                    expected_levels.insert(expected_levels.size(),
                        predict_level(i_in_ch.phase));
                end else begin
                    x_table[i_in_ch.point_index] = i_in_ch.point_x;
                    y_table[i_in_ch.point_index] = i_in_ch.point_y;
                end
            end
        end
        o_fail_count <= mismatch_count;
        o_pending    <= expected_levels.size();
    end

endmodule

// File: sim/testbench.sv
// Stimulus and verdict for the breakpoint envelope interpolator core.
`timescale 1ns / 1ps

module testbench;
    import bei_pkg::*;

    localparam int Q_MIN        = 32'sh8000_0000;
    localparam int Q_MAX        = 32'sh7FFF_FFFF;
    localparam int SETTLE_TICKS = 100;
    localparam int HOLD_TICKS   = 400;
    localparam int ITEM_GOAL    = 950;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               cfg_we;
    logic [COUNT_W-1:0] cfg_wdata;
    int                 fail_count;
    int                 pending;

    // Shared pacing controls; the stimulus process writes calm and hold_asked with nonblocking updates
    bit                 calm = 1'b0;
    int                 hold_asked = 0;
    int                 hold_served = 0;
    int                 hold_left = 0;

    // What the stimulus knows of the table, for aiming phases
    int                 cur_x [MAX_POINTS];
    int                 n_eff = 2;
    int                 items_sent = 0;

    bei_in_if  in_ch ();
    bei_out_if out_ch ();

    breakpoint_envelope_interpolator_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    envelope_checker level_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_ch      (in_ch),
        .i_out_ch     (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Offer one beat after a random gap, hold it until accepted
    task automatic send_beat(logic op, logic [IDX_W-1:0] idx, int x, int y, int ph);
        while (!calm && $urandom_range(0, 99) < 16) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.op          <= op;
        in_ch.point_index <= idx;
        in_ch.point_x     <= x;
        in_ch.point_y     <= y;
        in_ch.phase       <= ph;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    task automatic send_load(int slot, int x, int y);
        send_beat(OP_LOAD, IDX_W'(slot), x, y, int'($urandom));
        cur_x[slot] = x;
    endtask

    task automatic send_eval(int ph);
        send_beat(OP_EVAL, IDX_W'($urandom), int'($urandom), int'($urandom), ph);
    endtask

    // Drop valid, wait for every result, then let a trailing load finish
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic set_point_count(int value);
        cfg_we    <= 1'b1;
        cfg_wdata <= COUNT_W'(value);
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        n_eff = (value < 2) ? 2 : (value > MAX_POINTS) ? MAX_POINTS : value;
    endtask

    // Aim a phase inside a segment, at a breakpoint, next to one, at the extremes or anywhere
    function automatic int pick_phase();
        int              r, k, lo, hi;
        longint          span;
        longint unsigned r64;
        r = $urandom_range(0, 99);
        k = $urandom_range(0, n_eff - 2);
        if (r < 45) begin
            lo   = (cur_x[k] < cur_x[k+1]) ? cur_x[k] : cur_x[k+1];
            hi   = (cur_x[k] < cur_x[k+1]) ? cur_x[k+1] : cur_x[k];
            span = longint'(hi) - longint'(lo);
            r64  = {$urandom, $urandom};
            return int'(longint'(lo) + longint'(r64 % longint'(span + 1)));
        end else if (r < 60) begin
            return cur_x[$urandom_range(0, n_eff - 1)];
        end else if (r < 70) begin
            return cur_x[$urandom_range(0, n_eff - 1)] + (($urandom_range(0, 1) != 0) ? 1 : -1);
        end else if (r < 80) begin
            case ($urandom_range(0, 3))
                0: return Q_MIN;
                1: return Q_MAX;
                2: return 0;
                default: return -1;
            endcase
        end
        return int'($urandom);
    endfunction

    // Receiver: random stalls, one long hold-off on request
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left != 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else if (hold_asked != hold_served) begin
                hold_served++;
                hold_left = HOLD_TICKS;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= calm || ($urandom_range(0, 99) >= 16);
            end
        end
    end

    // Stimulus: directed corners, then randomized table phases
    initial begin
        int new_x [MAX_POINTS];
        int new_y [MAX_POINTS];
        int first_counts [6];
        int phase_no, value, style, evals, rot, slot, tmp, b;

        first_counts = '{16, 0, 1, 31, 17, 2};
        in_ch.valid       = 1'b0;
        in_ch.op          = OP_LOAD;
        in_ch.point_index = '0;
        in_ch.point_x     = '0;
        in_ch.point_y     = '0;
        in_ch.phase       = '0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        i_rst_n           = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Full-range rising segment: ends and near-ends
        send_load(0, Q_MIN, Q_MIN);
        send_load(1, Q_MAX, Q_MAX);
        send_eval(Q_MIN);
        send_eval(Q_MAX);
        send_eval(0);
        send_eval(Q_MIN + 1);
        send_eval(Q_MAX - 1);
        send_eval(-1);

        // Falling segment spanning the whole level range
        send_load(0, -65536, Q_MAX);
        send_load(1, 65536, Q_MIN);
        send_eval(0);
        send_eval(1);
        send_eval(-65535);
        send_eval(65535);
        send_eval(-65536);
        send_eval(65536);

        // Three points: shared breakpoint between two segments
        wait_idle();
        set_point_count(3);
        send_load(2, 262144, 0);
        send_load(1, 65536, 65536);
        send_eval(65536);
        send_eval(100000);
        send_eval(262143);
        send_eval(32'h0000_8000);

        phase_no = 0;
        while (items_sent < ITEM_GOAL) begin
            wait_idle();
            if (phase_no < 6)
                value = first_counts[phase_no];
            else if ($urandom_range(0, 99) < 80)
                value = $urandom_range(2, MAX_POINTS);
            else
                value = $urandom_range(0, 31);
            set_point_count(value);

            // One phase without any idling, one with a long receiver hold-off
            calm <= (phase_no == 3);
            if (phase_no == 5) hold_asked <= hold_asked + 1;

            // Build a fresh table: mostly sorted abscissas, some narrow with ties, some shuffled
            style = $urandom_range(0, 99);
            for (int a = 0; a < n_eff; a++) begin
                if (style >= 70 && style < 85)
                    new_x[a] = (int'($urandom_range(0, 64)) - 32) * 4096;
                else
                    new_x[a] = int'($urandom);
                if ($urandom_range(0, 99) < 15)
                    new_y[a] = ($urandom_range(0, 1) != 0) ? Q_MAX : Q_MIN;
                else
                    new_y[a] = int'($urandom);
            end
            if (style < 85) begin
                for (int a = 1; a < n_eff; a++) begin
                    tmp = new_x[a];
                    b   = a;
                    while (b > 0 && new_x[b-1] > tmp) begin
                        new_x[b] = new_x[b-1];
                        b--;
                    end
                    new_x[b] = tmp;
                end
                if ($urandom_range(0, 99) < 20) begin
                    tmp = $urandom_range(1, n_eff - 1);
                    new_x[tmp] = new_x[tmp-1];
                end
                if ($urandom_range(0, 99) < 10) begin
                    new_x[0]       = Q_MIN;
                    new_x[n_eff-1] = Q_MAX;
                end
            end

            // Load every slot in use, starting at a random slot
            rot = $urandom_range(0, n_eff - 1);
            for (int a = 0; a < n_eff; a++) begin
                slot = (a + rot) % n_eff;
                send_load(slot, new_x[slot], new_y[slot]);
            end

            // Evaluate, with the odd stray load that rewrites a slot
            evals = $urandom_range(8, 30);
            for (int e = 0; e < evals; e++) begin
                if ($urandom_range(0, 99) < 12)
                    send_load($urandom_range(0, MAX_POINTS - 1), int'($urandom), int'($urandom));
                else
                    send_eval(pick_phase());
            end
            phase_no++;
        end

        calm <= 1'b0;
        wait_idle();
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
